/* hw/rtl/swmc_pkg.sv */
package swmc_pkg;

    // width of one stroke width word
    localparam int WIDTH_W = 8;

    // number of distinct width levels held in the presence mask
    localparam int LEVELS = 1 << WIDTH_W;

    // presence mask is scanned one row of bits per cycle
    localparam int ROW_W     = 8;
    localparam int PICK_W    = $clog2(ROW_W);
    localparam int NUM_ROWS  = LEVELS / ROW_W;
    localparam int ROW_IDX_W = $clog2(NUM_ROWS);

    // distinct count can reach LEVELS itself
    localparam int DISTINCT_W = WIDTH_W + 1;

    // bits of one row popcount
    localparam int POP_W = PICK_W + 1;

    localparam int DEFAULT_MAX_POINTS = 64;

    typedef logic [WIDTH_W-1:0] width_t;

endpackage

/* hw/rtl/swmc_ram.sv */
module swmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ray_stroke_width_median_clamp.sv */
// flow: a point is taken at the accepting edge and its mask row is rewritten in the next cycle;
//   after the last point of a ray the first word comes out after mask update, row scan, bit
//   pick, buffer read and clamp, then one word per cycle in arrival order
// busy: through the mask update after a plain point, and through scan, pick and emit after the
//   last point of a ray; the full 32-row mask scan, which also clears the mask, sets the overhead
// reset: rst_n async active low; a pass zeroes all 32 mask rows, busy high; results never stall
module ray_stroke_width_median_clamp #(
    parameter int MAX_POINTS = swmc_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  swmc_pkg::width_t     width,
    input  logic                 last_point,
    output logic                 result_strobe,
    output swmc_pkg::width_t     refined_width,
    output logic                 last_result,
    output logic                 overflowed
);

    import swmc_pkg::*;

    // buffer address and fill count widths follow the buffer depth
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    // row pointer runs one past the last row so the final returned row is consumed
    localparam int PTR_W = ROW_IDX_W + 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // zeroing the mask ram after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for the next width of a ray
    localparam logic [2:0] ST_MARK  = 3'd2;  // setting the width's bit in its mask row
    localparam logic [2:0] ST_SCAN  = 3'd3;  // counting set mask bits row by row
    localparam logic [2:0] ST_PICK  = 3'd4;  // locating the median bit in its row
    localparam logic [2:0] ST_EMIT  = 3'd5;  // reading the buffer back out

    // control state
    logic [2:0]            state_reg,      state_next;
    logic [DISTINCT_W-1:0] distinct_reg,   distinct_next;
    logic [CW-1:0]         count_reg,      count_next;
    logic                  ovf_reg,        ovf_next;
    logic [PTR_W-1:0]      row_ptr_reg,    row_ptr_next;
    logic                  row_valid_reg,  row_valid_next;
    logic                  found_reg,      found_next;
    logic [DISTINCT_W-1:0] seen_acc_reg,   seen_acc_next;
    logic [CW-1:0]         emit_idx_reg,   emit_idx_next;
    logic                  rd_valid_reg,   rd_valid_next;
    logic                  strobe_reg,     strobe_next;

    // payload
    width_t                hold_width_reg, hold_width_next;
    logic                  hold_last_reg,  hold_last_next;
    logic [ROW_W-1:0]      row_bits_reg,   row_bits_next;
    logic [PICK_W-1:0]     rank_reg,       rank_next;
    logic [ROW_IDX_W-1:0]  med_row_reg,    med_row_next;
    width_t                median_reg,     median_next;
    logic                  rd_last_reg,    rd_last_next;
    logic                  rd_ovf_reg,     rd_ovf_next;
    width_t                refined_reg,    refined_next;
    logic                  last_out_reg,   last_out_next;
    logic                  ovf_out_reg,    ovf_out_next;

    logic                  accept;
    logic                  count_full;
    logic [DISTINCT_W-1:0] target;
    logic [ROW_IDX_W-1:0]  mask_raddr;
    logic                  mask_we;
    logic [ROW_IDX_W-1:0]  mask_waddr;
    logic [ROW_W-1:0]      mask_wdata;
    logic [ROW_W-1:0]      mask_rdata;
    logic [ROW_W-1:0]      mark_bit;
    logic [ROW_IDX_W-1:0]  proc_row;
    logic                  proc_last;
    logic [POP_W-1:0]      row_pop;
    logic [DISTINCT_W-1:0] seen_sum;
    logic                  row_hit;
    logic [PICK_W-1:0]     pick_idx;
    logic [POP_W-1:0]      pick_cnt;
    logic                  pick_found;
    logic                  emit_last;
    width_t                rd_data;

    assign busy       = (state_reg != ST_IDLE) || rd_valid_reg;
    assign accept     = start && !busy;
    assign count_full = (count_reg == CW'(MAX_POINTS));

    // bit of the held width inside its mask row
    assign mark_bit = ROW_W'(1) << hold_width_reg[PICK_W-1:0];

    // the median sits at position distinct/2 among the set mask bits
    assign target    = distinct_reg >> 1;
    // returned row is the one addressed in the previous cycle
    assign proc_row  = row_ptr_reg[ROW_IDX_W-1:0] - ROW_IDX_W'(1);
    assign proc_last = (proc_row == ROW_IDX_W'(NUM_ROWS - 1));
    assign row_pop   = POP_W'($countones(mask_rdata));
    assign seen_sum  = seen_acc_reg + DISTINCT_W'(row_pop);
    assign row_hit   = !found_reg && (seen_sum > target);

    // find the set bit of rank rank_reg within the captured row
    always_comb
    begin
        pick_idx   = '0;
        pick_cnt   = '0;
        pick_found = 1'b0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (row_bits_reg[i] && !pick_found && (pick_cnt == POP_W'(rank_reg)))
            begin
                pick_idx   = PICK_W'(i);
                pick_found = 1'b1;
            end
            pick_cnt = pick_cnt + POP_W'(row_bits_reg[i]);
        end
    end

    assign emit_last = ((emit_idx_reg + CW'(1)) == count_reg);

    // width buffer: written while loading, read back in order while emitting
    swmc_ram #(
        .WIDTH (WIDTH_W),
        .DEPTH (MAX_POINTS)
    ) u_buf (
        .clk   (clk),
        .we    (accept && !count_full),
        .waddr (count_reg[AW-1:0]),
        .wdata (width),
        .raddr (emit_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // presence mask ram ports
    // a row is read at the accepting edge and written back in the mark cycle; busy holds the
    // next word off until that write is done, so no two accesses to a row overlap
    always_comb
    begin
        mask_we    = 1'b0;
        mask_waddr = row_ptr_reg[ROW_IDX_W-1:0];
        mask_wdata = '0;
        mask_raddr = row_ptr_reg[ROW_IDX_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mask_we = 1'b1;
            end
            ST_IDLE:
            begin
                mask_raddr = width[WIDTH_W-1:PICK_W];
            end
            ST_MARK:
            begin
                mask_we    = 1'b1;
                mask_waddr = hold_width_reg[WIDTH_W-1:PICK_W];
                mask_wdata = mask_rdata | mark_bit;
            end
            ST_SCAN:
            begin
                // each row is zeroed once it has been counted
                mask_we    = row_valid_reg;
                mask_waddr = proc_row;
            end
            default:
            begin
                mask_we = 1'b0;
            end
        endcase
    end

    swmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_mask (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        distinct_next   = distinct_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        row_ptr_next    = row_ptr_reg;
        row_valid_next  = 1'b0;
        found_next      = found_reg;
        seen_acc_next   = seen_acc_reg;
        emit_idx_next   = emit_idx_reg;
        rd_valid_next   = 1'b0;
        hold_width_next = hold_width_reg;
        hold_last_next  = hold_last_reg;
        row_bits_next   = row_bits_reg;
        rank_next       = rank_reg;
        med_row_next    = med_row_reg;
        median_next     = median_reg;
        rd_last_next    = rd_last_reg;
        rd_ovf_next     = rd_ovf_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (row_ptr_reg[ROW_IDX_W-1:0] == ROW_IDX_W'(NUM_ROWS - 1))
                begin
                    row_ptr_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    row_ptr_next = row_ptr_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    hold_width_next = width;
                    hold_last_next  = last_point;
                    // full buffer: word still counts toward the median but is dropped
                    if (count_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                // new distinct level bumps the distinct count
                if (!(|(mask_rdata & mark_bit)))
                begin
                    distinct_next = distinct_reg + DISTINCT_W'(1);
                end
                if (hold_last_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (row_ptr_reg < PTR_W'(NUM_ROWS))
                begin
                    row_valid_next = 1'b1;
                    row_ptr_next   = row_ptr_reg + PTR_W'(1);
                end
                if (row_valid_reg)
                begin
                    seen_acc_next = seen_sum;
                    if (row_hit)
                    begin
                        row_bits_next = mask_rdata;
                        rank_next     = PICK_W'(target - seen_acc_reg);
                        med_row_next  = proc_row;
                        found_next    = 1'b1;
                    end
                    // every row is visited so the whole mask ends up cleared
                    if (proc_last)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                median_next   = {med_row_reg, pick_idx};
                distinct_next = '0;
                found_next    = 1'b0;
                seen_acc_next = '0;
                row_ptr_next  = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                rd_valid_next = 1'b1;
                rd_last_next  = emit_last;
                rd_ovf_next   = ovf_reg;
                if (emit_last)
                begin
                    emit_idx_next = '0;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output stage: clamp the returned buffer word to the median
    assign strobe_next   = rd_valid_reg;
    assign refined_next  = (rd_data > median_reg) ? median_reg : rd_data;
    assign last_out_next = rd_last_reg;
    assign ovf_out_next  = rd_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            distinct_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            row_ptr_reg   <= '0;
            row_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            seen_acc_reg  <= '0;
            emit_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            distinct_reg  <= distinct_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            row_ptr_reg   <= row_ptr_next;
            row_valid_reg <= row_valid_next;
            found_reg     <= found_next;
            seen_acc_reg  <= seen_acc_next;
            emit_idx_reg  <= emit_idx_next;
            rd_valid_reg  <= rd_valid_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_width_reg <= hold_width_next;
        hold_last_reg  <= hold_last_next;
        row_bits_reg   <= row_bits_next;
        rank_reg       <= rank_next;
        med_row_reg    <= med_row_next;
        median_reg     <= median_next;
        rd_last_reg    <= rd_last_next;
        rd_ovf_reg     <= rd_ovf_next;
        refined_reg    <= refined_next;
        last_out_reg   <= last_out_next;
        ovf_out_reg    <= ovf_out_next;
    end

    assign result_strobe = strobe_reg;
    assign refined_width = refined_reg;
    assign last_result   = last_out_reg;
    assign overflowed    = ovf_out_reg;

endmodule

/* hw/rtl/swmc_checker.sv */
module swmc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_point,
    input logic result_strobe,
    input logic last_result,
    input logic overflowed
);

    // last point of a ray starts the median search
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_point |=> busy)
        else $error("block not busy after last point of a ray");

    // other points keep the block busy only for the mask update
    a_point_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_point |=> busy ##1 !busy)
        else $error("plain point not taken in two cycles");

    // words of one ray come out back to back
    a_ray_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |=> result_strobe)
        else $error("gap inside a ray's result words");

    // overflow mark is the same on every word of a ray
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |=> overflowed == $past(overflowed))
        else $error("overflow mark changed within a ray");

    // rays are separated by a gap: no word directly follows the last word of a ray
    a_ray_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_result |=> !result_strobe)
        else $error("result word directly after end of ray");

endmodule

bind ray_stroke_width_median_clamp swmc_checker u_swmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .last_point    (last_point),
    .result_strobe (result_strobe),
    .last_result   (last_result),
    .overflowed    (overflowed)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import swmc_pkg::*;

    // buffer depth of the instance under test
    localparam int MAX_PTS      = DEFAULT_MAX_POINTS;
    localparam int CLK_HALF     = 6;
    // worst run: every word a one-point ray with a long sender gap, plus the scan, pick and
    // emit of each ray; the limit is several times that
    localparam int CYCLE_LIMIT  = 400000;
    // row scan, bit pick, buffer reads and the result pipe
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_PRINTS   = 40;

    // one expected result word
    typedef struct {
        width_t refined;
        logic   last;
        logic   ovf;
    } clamp_word_t;

    // width generation styles for a ray
    typedef enum int {
        WIDTHS_ANY,
        WIDTHS_NARROW,
        WIDTHS_EXTREME
    } width_style_e;

    logic   clk           = 1'b0;
    logic   rst_n         = 1'b0;
    logic   start         = 1'b0;
    width_t width         = '0;
    logic   last_point    = 1'b0;
    logic   busy;
    logic   result_strobe;
    width_t refined_width;
    logic   last_result;
    logic   overflowed;

    // predictor copy of the block state
    bit [LEVELS-1:0] seen_levels;
    width_t          ray_buf [MAX_PTS];
    int unsigned     ray_count;
    bit              ray_ovf;

    // results still owed by the block, oldest first
    clamp_word_t clamp_q [$];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned words_sent     = 0;
    // chance in a hundred that the sender idles after a word
    int          idle_pct       = 0;

    ray_stroke_width_median_clamp #(
        .MAX_POINTS (MAX_PTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .width         (width),
        .last_point    (last_point),
        .result_strobe (result_strobe),
        .refined_width (refined_width),
        .last_result   (last_result),
        .overflowed    (overflowed)
    );

    always #(CLK_HALF) clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // median of the distinct widths seen in the current ray
    function automatic width_t ray_median_level();
        int distinct_n = 0;
        int target;
        int seen_n = 0;
        for (int v = 0; v < LEVELS; v++)
            distinct_n += seen_levels[v];
        target = distinct_n / 2;
        for (int v = 0; v < LEVELS; v++)
        begin
            if (seen_levels[v])
            begin
                if (seen_n == target)
                    return width_t'(v);
                seen_n++;
            end
        end
        return '1;
    endfunction

    // record one accepted word; on the last point queue the clamped ray
    function automatic void predict_point(input width_t w, input logic last);
        width_t      med;
        clamp_word_t exp_word;
        seen_levels[w] = 1'b1;
        // widths past a full buffer still vote for the median
        if (ray_count < MAX_PTS)
        begin
            ray_buf[ray_count] = w;
            ray_count++;
        end
        else
            ray_ovf = 1'b1;
        if (!last)
            return;
        med = ray_median_level();
        for (int k = 0; k < ray_count; k++)
        begin
            exp_word.refined = (ray_buf[k] > med) ? med : ray_buf[k];
            exp_word.last    = (k + 1 == ray_count);
            exp_word.ovf     = ray_ovf;
            clamp_q = {clamp_q, exp_word};
        end
        seen_levels = '0;
        ray_count   = 0;
        ray_ovf     = 1'b0;
    endfunction

    // hold one word on the inputs until the block takes it
    task automatic send_word(input width_t w, input logic last);
        int gap;
        start      <= 1'b1;
        width      <= w;
        last_point <= last;
        // busy read here is the value from before the edge
        do
            @(posedge clk);
        while (busy);
        predict_point(w, last);
        words_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            // mostly short gaps, some long enough to land on the emit phase
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_ray_list(input width_t vals [$]);
        foreach (vals[k])
            send_word(vals[k], k == vals.size() - 1);
    endtask

    function automatic width_t pick_width(input width_style_e style, input width_t base);
        case (style)
            WIDTHS_NARROW:
                return base + width_t'($urandom_range(0, 7));
            WIDTHS_EXTREME:
            begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return width_t'($urandom);
                endcase
            end
            default:
                return width_t'($urandom);
        endcase
    endfunction

    task automatic send_random_ray(input int len);
        width_style_e style;
        width_t       base;
        style = width_style_e'($urandom_range(0, 2));
        base  = width_t'($urandom);
        for (int k = 0; k < len; k++)
            send_word(pick_width(style, base), k == len - 1);
    endtask

    // short hand-built rays: extremes, even and odd distinct counts, repeats
    task automatic test_directed_rays();
        width_t ray [$];
        ray = '{8'd0};
        send_ray_list(ray);
        ray = '{8'd255};
        send_ray_list(ray);
        // two distinct levels pick the upper one
        ray = '{8'd255, 8'd0};
        send_ray_list(ray);
        ray = '{8'd0, 8'd255, 8'd7};
        send_ray_list(ray);
        // all equal widths pass untouched
        ray = '{8'd9, 8'd9, 8'd9, 8'd9};
        send_ray_list(ray);
        ray = '{8'd200, 8'd100, 8'd50, 8'd25, 8'd128, 8'd64, 8'd1, 8'd170};
        send_ray_list(ray);
        // repeats count once toward the median
        ray = '{8'd3, 8'd3, 8'd250, 8'd250, 8'd1};
        send_ray_list(ray);
    endtask

    // exactly full buffer, one point over, and a long tail past capacity
    task automatic test_buffer_limits();
        for (int k = 0; k < MAX_PTS; k++)
            send_word(width_t'($urandom), k == MAX_PTS - 1);
        // overflowing last point brings a new top level
        for (int k = 0; k < MAX_PTS; k++)
            send_word(width_t'($urandom_range(100, 120)), 1'b0);
        send_word(8'd255, 1'b1);
        // dropped low widths drag the median down
        for (int k = 0; k < MAX_PTS; k++)
            send_word(width_t'($urandom_range(128, 255)), 1'b0);
        for (int k = 0; k < 30; k++)
            send_word(width_t'($urandom_range(0, 127)), k == 29);
    endtask

    // random rays, mostly short, some long, a few past capacity
    task automatic test_random_rays(input int word_budget, input int pct);
        int unsigned stop_at;
        int          r;
        idle_pct = pct;
        stop_at  = words_sent + word_budget;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_random_ray($urandom_range(1, 8));
            else if (r < 94)
                send_random_ray($urandom_range(9, MAX_PTS));
            else
                send_random_ray($urandom_range(MAX_PTS + 1, MAX_PTS + 30));
        end
        idle_pct = 0;
    endtask

    // result checking: every strobed word against the oldest expectation
    always @(posedge clk)
    begin
        clamp_word_t exp_word;
        if (rst_n && result_strobe)
        begin
            if (clamp_q.size() == 0)
                report_mismatch($sformatf("unexpected result width=%0d last=%0b ovf=%0b",
                                          refined_width, last_result, overflowed));
            else
            begin
                exp_word = clamp_q.pop_front();
                if (refined_width !== exp_word.refined)
                    report_mismatch($sformatf("refined_width %0d, expected %0d",
                                              refined_width, exp_word.refined));
                if (last_result !== exp_word.last)
                    report_mismatch($sformatf("last_result %0b, expected %0b",
                                              last_result, exp_word.last));
                if (overflowed !== exp_word.ovf)
                    report_mismatch($sformatf("overflowed %0b, expected %0b",
                                              overflowed, exp_word.ovf));
            end
        end
    end

    initial
    begin
        seen_levels = '0;
        ray_count   = 0;
        ray_ovf     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_rays();
        test_buffer_limits();
        test_random_rays(40, 0);
        test_random_rays(40, 49);
        test_random_rays(40, 0);
        test_random_rays(40, 9);
        start <= 1'b0;

        // let the last ray drain, then some slack for stray words
        while (clamp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (clamp_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", clamp_q.size()));

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/swmc_pkg.sv
hw/rtl/swmc_ram.sv
hw/rtl/ray_stroke_width_median_clamp.sv
hw/rtl/swmc_checker.sv
tb/tb_top.sv
